FILE: src/kfm_pkg.sv
// ----------------------------------------------------------------------------
// Keypad Fn-modifier scanner package
// Shared types, command codes, register indexes and the key priority encoder.
// ----------------------------------------------------------------------------
package kfm_pkg;

    localparam int unsigned PIN_W  = 8;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned CMD_W  = 4;
    localparam int unsigned HOLD_W = 10;
    localparam int unsigned IDX_W  = 1;

    localparam int unsigned S_TDATA_W = PIN_W + TIME_W;
    localparam int unsigned M_TDATA_W = 8;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_NONE = 4'd0;
    localparam logic [CMD_W-1:0] CMD_MENU = 4'd13;
    localparam logic [CMD_W-1:0] FN_SHIFT = 4'd6;

    // Bit position of the Fn modifier in the active-high key vector.
    localparam int unsigned FN_BIT = 6;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_DEVICE_PRESENT = 1'd0;
    localparam logic [IDX_W-1:0] REG_HOLD_OFF       = 1'd1;

    // Reset values of the configuration registers.
    localparam logic              DEVICE_PRESENT_RST = 1'b1;
    localparam logic [HOLD_W-1:0] HOLD_OFF_RST       = 10'd50;

    typedef struct packed {
        logic              device_present;
        logic [HOLD_W-1:0] hold_off_ms;
    } kfm_cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0]  held_code;
        logic [TIME_W-1:0] emit_time;
        logic              fn_down;
        logic              key_seen;
        logic [TIME_W-1:0] fn_time;
    } kfm_state_t;

    // Priority encoder over the six keys: bits 0, 1, 2, 3, 5, 4 give 1 to 6.
    function automatic logic [CMD_W-1:0] encode_keys(input logic [PIN_W-1:0] act);
        logic [CMD_W-1:0] code;
        code = CMD_NONE;
        if (act[0])      code = 4'd1;
        else if (act[1]) code = 4'd2;
        else if (act[2]) code = 4'd3;
        else if (act[3]) code = 4'd4;
        else if (act[5]) code = 4'd5;
        else if (act[4]) code = 4'd6;
        return code;
    endfunction

endpackage

FILE: src/kfm_cfg_regs.sv
// ----------------------------------------------------------------------------
// Keypad scanner configuration registers
// Holds the device-present flag and the hold-off time, written by index.
// ----------------------------------------------------------------------------
module kfm_cfg_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [kfm_pkg::IDX_W-1:0]  cfg_index,
    input  logic [kfm_pkg::HOLD_W-1:0] cfg_data,
    output kfm_pkg::kfm_cfg_t          cfg
);
    import kfm_pkg::*;

    kfm_cfg_t cfg_reg;
    kfm_cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_DEVICE_PRESENT: cfg_next.device_present = cfg_data[0];
                REG_HOLD_OFF:       cfg_next.hold_off_ms    = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_present <= DEVICE_PRESENT_RST;
            cfg_reg.hold_off_ms    <= HOLD_OFF_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/kfm_decide.sv
// ----------------------------------------------------------------------------
// Keypad scanner poll decision
// Combinational lockout check, key encoding and Fn handling for one poll.
// ----------------------------------------------------------------------------
module kfm_decide (
    input  kfm_pkg::kfm_cfg_t          cfg,
    input  kfm_pkg::kfm_state_t        state_cur,
    input  logic [kfm_pkg::PIN_W-1:0]  pin_levels,
    input  logic [kfm_pkg::TIME_W-1:0] now_ms,
    output kfm_pkg::kfm_state_t        state_nxt,
    output logic [kfm_pkg::CMD_W-1:0]  command
);
    import kfm_pkg::*;

    logic [PIN_W-1:0]  act;
    logic [CMD_W-1:0]  code;
    logic [TIME_W-1:0] since_emit;
    logic [TIME_W-1:0] since_fn;
    logic [TIME_W-1:0] hold_off_ext;
    logic              locked;
    logic              fn_expired;

    assign act          = ~pin_levels;
    assign code         = encode_keys(act);
    assign hold_off_ext = {{(TIME_W-HOLD_W){1'b0}}, cfg.hold_off_ms};
    // Differences wrap modulo 2^32, exactly as the free-running clock does.
    assign since_emit   = now_ms - state_cur.emit_time;
    assign since_fn     = now_ms - state_cur.fn_time;
    assign locked       = since_emit < hold_off_ext;
    assign fn_expired   = since_fn >= hold_off_ext;

    always_comb begin
        state_nxt = state_cur;
        command   = CMD_NONE;
        if (cfg.device_present && !locked) begin
            if (code != CMD_NONE) begin
                // A key emits only on the first poll of its press.
                if (state_cur.held_code == CMD_NONE) begin
                    command             = act[FN_BIT] ? code + FN_SHIFT : code;
                    state_nxt.held_code = command;
                    state_nxt.emit_time = now_ms;
                    state_nxt.key_seen  = 1'b1;
                end
            end else if (act[FN_BIT]) begin
                state_nxt.held_code = CMD_NONE;
                state_nxt.fn_down   = 1'b1;
                state_nxt.fn_time   = now_ms;
            end else if (state_cur.fn_down && !state_cur.key_seen) begin
                if (fn_expired) begin
                    command             = CMD_MENU;
                    state_nxt.fn_down   = 1'b0;
                    state_nxt.key_seen  = 1'b0;
                    state_nxt.held_code = CMD_NONE;
                    state_nxt.emit_time = now_ms;
                end
            end else begin
                state_nxt.fn_down   = 1'b0;
                state_nxt.key_seen  = 1'b0;
                state_nxt.held_code = CMD_NONE;
            end
        end
    end

endmodule

FILE: src/keypad_fn_modifier_scanner.sv
// A poll's command passes the input register, then the result register.
// Throughput: one poll per cycle while m_tready is high; scan state updates in
// the same cycle the result register loads; polls see the prior poll's state.
// Reset: aresetn is synchronous, active low; it empties both pipeline
// registers, clears the scan state to zero and restores the configuration
// to device present with a 50 ms hold-off.
// ----------------------------------------------------------------------------
// Keypad Fn-modifier scanner
// Turns polls of a seven-key pad with Fn modifier into one command per poll.
// ----------------------------------------------------------------------------
module keypad_fn_modifier_scanner (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Poll channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata, lowest bit first: pin_levels [7:0], now_ms [39:8].
    input  logic [kfm_pkg::S_TDATA_W-1:0] s_tdata,
    // Command channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata, lowest bit first: command [3:0], zero fill [7:4].
    output logic [kfm_pkg::M_TDATA_W-1:0] m_tdata,
    // Configuration write channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kfm_pkg::IDX_W-1:0]     cfg_index,
    input  logic [kfm_pkg::HOLD_W-1:0]    cfg_data
);
    import kfm_pkg::*;

    kfm_cfg_t cfg;

    // Input register: holds one accepted poll until the decision logic
    // can hand its command on to the result register.
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [PIN_W-1:0]  pin_reg;
    logic [TIME_W-1:0] now_reg;

    // Result register.
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CMD_W-1:0]  cmd_reg;

    // Scan state carried from poll to poll.
    kfm_state_t        state_reg;
    kfm_state_t        state_next;
    kfm_state_t        state_calc;
    logic [CMD_W-1:0]  cmd_calc;

    logic              advance;
    logic              s_xfer;

    kfm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kfm_decide u_decide (
        .cfg        (cfg),
        .state_cur  (state_reg),
        .pin_levels (pin_reg),
        .now_ms     (now_reg),
        .state_nxt  (state_calc),
        .command    (cmd_calc)
    );

    // The held poll moves forward whenever the result register is empty or
    // its command is being taken in this cycle. A new poll is accepted
    // whenever the input register is empty or is emptying, so a waiting
    // result never blocks the input side by itself.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // The scan state commits only when the poll's command is committed.
    assign state_next = advance ? state_calc : state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            pin_reg <= s_tdata[PIN_W-1:0];
            now_reg <= s_tdata[PIN_W+TIME_W-1:PIN_W];
        end
        if (advance) begin
            cmd_reg <= cmd_calc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-CMD_W){1'b0}}, cmd_reg};

    // A key code is only ever held after a key has emitted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.held_code != CMD_NONE) |-> state_reg.key_seen)
        else $error("held key code without key_seen");

    // With no device present a poll leaves the scan state untouched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !cfg.device_present) |=> $stable(state_reg))
        else $error("scan state changed with device absent");

    // A menu command resolves the Fn press completely.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && cmd_calc == CMD_MENU) |=>
        (state_reg.held_code == CMD_NONE && !state_reg.fn_down && !state_reg.key_seen))
        else $error("menu command left Fn state pending");

    // Only defined command codes reach the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (cmd_reg <= CMD_MENU))
        else $error("command code out of range");

    // The input side stalls only while a poll is held and cannot move on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

endmodule
